>>> rtl/gqg_pkg.sv
// shared types, constants and codes for the group quantized gemv row block
package gqg_pkg;

	localparam int LANES = 8;
	localparam int CODE_W = 8;
	localparam int ACT_W = 16;
	localparam int SCALE_W = 16;
	localparam int P1_W = CODE_W + SCALE_W;
	localparam int PROD_W = P1_W + ACT_W;
	localparam int GS_W = 13;
	localparam int OUT_W = 48;
	localparam int LANE_W = 3;

	localparam int DEF_MAX_GROUPS = 64;
	localparam int DEF_MAX_COLUMNS = 8192;
	localparam int DEF_ACC_WIDTH = 48;

	localparam logic [GS_W-1:0] DEF_GROUP = 13'd128;

	// weight packing codes
	localparam logic [1:0] FMT_2BIT = 2'd0;
	localparam logic [1:0] FMT_3BIT = 2'd1;
	localparam logic [1:0] FMT_4BIT = 2'd2;
	localparam logic [1:0] FMT_8BIT = 2'd3;

	// item kinds
	localparam logic ACT_LOAD_SCALE = 1'b0;
	localparam logic ACT_CHUNK = 1'b1;

	// register indexes
	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_GROUP = 1'b1;

	typedef struct packed {
		logic action;
		logic [23:0] packed_bits;
		logic signed [ACT_W-1:0] act0;
		logic signed [ACT_W-1:0] act1;
		logic signed [ACT_W-1:0] act2;
		logic signed [ACT_W-1:0] act3;
		logic signed [ACT_W-1:0] act4;
		logic signed [ACT_W-1:0] act5;
		logic signed [ACT_W-1:0] act6;
		logic signed [ACT_W-1:0] act7;
		logic signed [SCALE_W-1:0] scale_value;
		logic row_end;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] row_sum;
		logic saturated;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic action;
		logic [LANE_W-1:0] last_lane;
		logic [LANES-1:0][CODE_W-1:0] codes;
		logic [LANES-1:0][ACT_W-1:0] acts;
		logic [SCALE_W-1:0] scale;
		logic row_end;
	} cmd_t;

endpackage

>>> rtl/gqg_front.sv
// front: accepts items, unpacks weight codes and queues classified commands
module gqg_front
	import gqg_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic [1:0] weight_format,
	input logic push,
	output logic full,
	input item_t item,
	output logic hd_valid,
	output cmd_t hd,
	input logic hd_pop
);

	cmd_t cmd;
	cmd_t fifo_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;

	// unpack codes and remove the offset of the 2, 3 and 4 bit formats
	always_comb begin
		cmd = '0;
		cmd.action = item.action;
		cmd.row_end = item.row_end;
		cmd.scale = item.scale_value;
		cmd.acts[0] = item.act0;
		cmd.acts[1] = item.act1;
		cmd.acts[2] = item.act2;
		cmd.acts[3] = item.act3;
		cmd.acts[4] = item.act4;
		cmd.acts[5] = item.act5;
		cmd.acts[6] = item.act6;
		cmd.acts[7] = item.act7;
		case (weight_format)
			FMT_2BIT: begin
				cmd.last_lane = 3'd3;
				for (int k = 0; k < 4; k++)
					cmd.codes[k] = CODE_W'({6'd0, item.packed_bits[2*k +: 2]}) - 8'd2;
			end
			FMT_3BIT: begin
				cmd.last_lane = 3'd7;
				for (int k = 0; k < 8; k++)
					cmd.codes[k] = CODE_W'({5'd0, item.packed_bits[3*k +: 3]}) - 8'd4;
			end
			FMT_4BIT: begin
				cmd.last_lane = 3'd1;
				for (int k = 0; k < 2; k++)
					cmd.codes[k] = CODE_W'({4'd0, item.packed_bits[4*k +: 4]}) - 8'd8;
			end
			default: begin
				cmd.last_lane = 3'd0;
				cmd.codes[0] = item.packed_bits[7:0];
			end
		endcase
	end

	assign full = (cnt_q == 2'd2);
	assign hd_valid = (cnt_q != 2'd0);
	assign hd = fifo_q[rd_q];
	assign do_push = push && !full;

	// two entry command queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push)
				wr_q <= ~wr_q;
			if (hd_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, hd_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			fifo_q[wr_q] <= cmd;
	end

endmodule

>>> rtl/gqg_back.sv
// back: column sequencer, scale store, multiply pipeline and saturating accumulator
module gqg_back
	import gqg_pkg::*;
#(
	parameter int MAX_GROUPS = DEF_MAX_GROUPS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic [GS_W-1:0] grp_len,
	input logic hd_valid,
	input cmd_t hd,
	output logic hd_pop,
	output logic empty,
	input logic pop,
	output result_t result
);

	localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GIW = $clog2(MAX_GROUPS + 1);
	localparam int CW = $clog2(MAX_COLUMNS + 1);
	localparam int SW = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
	localparam logic signed [SW-1:0] HI = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SW-1:0] LO = ~HI;

	logic signed [SCALE_W-1:0] mem [MAX_GROUPS];

	logic [GIW-1:0] ptr_q;
	logic [CW-1:0] col_q;
	logic [GIW-1:0] gidx_q;
	logic [GS_W-1:0] within_q;
	logic [LANE_W-1:0] lane_q;

	logic v_s1, last_s1, zero_s1;
	logic signed [CODE_W-1:0] code_s1;
	logic signed [ACT_W-1:0] act_s1;
	logic signed [SCALE_W-1:0] scale_s1;
	logic v_s2, last_s2;
	logic signed [P1_W-1:0] p1_s2;
	logic signed [ACT_W-1:0] act_s2;
	logic v_s3, last_s3;
	logic signed [PROD_W-1:0] p2_s3;

	logic signed [ACC_WIDTH-1:0] acc_q;
	logic clip_q;
	logic out_v_q;
	logic signed [OUT_W-1:0] out_sum_q;
	logic out_clip_q;

	logic st;
	logic issue;
	logic lane_done;
	logic col_last;
	logic contrib;
	logic [GS_W-1:0] gs;
	logic [GS_W:0] within_nx;
	logic signed [CODE_W-1:0] code_sel;
	logic signed [SW-1:0] sum;
	logic signed [ACC_WIDTH-1:0] acc_nx;
	logic clip_nx;

	// stall the whole back pipe while a row result cannot be handed over
	assign st = v_s3 && last_s3 && out_v_q && !pop;
	assign lane_done = (lane_q == hd.last_lane);
	assign issue = hd_valid && !st && (hd.action == ACT_CHUNK);
	assign hd_pop = hd_valid && !st && ((hd.action == ACT_LOAD_SCALE) || lane_done);
	assign col_last = hd.row_end && lane_done;
	assign contrib = (CW'(col_q) < CW'(MAX_COLUMNS));
	assign gs = (grp_len == '0) ? DEF_GROUP : grp_len;
	assign within_nx = {1'b0, within_q} + 1'b1;
	assign code_sel = contrib ? signed'(hd.codes[lane_q]) : '0;

	// column and group counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			col_q <= '0;
			gidx_q <= '0;
			within_q <= '0;
			lane_q <= '0;
		end else if (hd_valid && !st) begin
			if (hd.action == ACT_LOAD_SCALE) begin
				if (ptr_q < GIW'(MAX_GROUPS))
					ptr_q <= ptr_q + 1'b1;
			end else begin
				lane_q <= lane_done ? '0 : lane_q + 1'b1;
				if (col_last) begin
					ptr_q <= '0;
					col_q <= '0;
					gidx_q <= '0;
					within_q <= '0;
				end else if (contrib) begin
					col_q <= col_q + 1'b1;
					if (within_nx >= {1'b0, gs}) begin
						within_q <= '0;
						if (gidx_q < GIW'(MAX_GROUPS))
							gidx_q <= gidx_q + 1'b1;
					end else begin
						within_q <= within_nx[GS_W-1:0];
					end
				end
			end
		end
	end

	// scale store with registered read
	always_ff @(posedge clk) begin
		if (hd_valid && !st && hd.action == ACT_LOAD_SCALE && ptr_q < GIW'(MAX_GROUPS))
			mem[ptr_q[GW-1:0]] <= hd.scale;
		if (!st) begin
			scale_s1 <= mem[gidx_q[GW-1:0]];
			code_s1 <= code_sel;
			act_s1 <= hd.acts[lane_q];
			zero_s1 <= (gidx_q >= GIW'(MAX_GROUPS));
			p1_s2 <= P1_W'(code_s1) * P1_W'(zero_s1 ? SCALE_W'(0) : scale_s1);
			act_s2 <= act_s1;
			p2_s3 <= PROD_W'(p1_s2) * PROD_W'(act_s2);
		end
	end

	// pipe valid and row end flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			last_s1 <= 1'b0;
			last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else if (!st) begin
			v_s1 <= issue;
			last_s1 <= issue && col_last;
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			v_s3 <= v_s2;
			last_s3 <= last_s2;
		end
	end

	// saturating add
	always_comb begin
		sum = SW'(acc_q) + SW'(p2_s3);
		acc_nx = sum[ACC_WIDTH-1:0];
		clip_nx = clip_q;
		if (sum > HI) begin
			acc_nx = HI[ACC_WIDTH-1:0];
			clip_nx = 1'b1;
		end else if (sum < LO) begin
			acc_nx = LO[ACC_WIDTH-1:0];
			clip_nx = 1'b1;
		end
	end

	// accumulator and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			clip_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q)
				out_v_q <= 1'b0;
			if (v_s3 && !st) begin
				if (last_s3) begin
					acc_q <= '0;
					clip_q <= 1'b0;
					out_v_q <= 1'b1;
				end else begin
					acc_q <= acc_nx;
					clip_q <= clip_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && last_s3 && !st) begin
			out_sum_q <= OUT_W'(64'(acc_nx));
			out_clip_q <= clip_nx;
		end
	end

	assign empty = !out_v_q;
	assign result.row_sum = out_sum_q;
	assign result.saturated = out_clip_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		st |=> (v_s3 && last_s3))
		else $error("row end transaction lost while stalled");
	a_row_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && last_s3 && !st) |=> (acc_q == '0 && !clip_q && out_v_q))
		else $error("accumulator not cleared after row end");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q <= GIW'(MAX_GROUPS)) && (gidx_q <= GIW'(MAX_GROUPS)))
		else $error("scale pointer or group index out of range");

endmodule

>>> rtl/group_quant_gemv_row.sv
// top level: register port, front queue and back compute pipe
// a row end result passes stages s1, s2 and s3 and then the result register after its last column issues
// the back takes one scale load or one chunk column per cycle while not stalled; a chunk holds 1, 2, 4 or 8 columns
// the rate is set by the back column sequencer, which feeds one multiplier chain
// a two entry queue lets items be taken while the back works or a result waits
// reset clears counters, accumulator and registers; the scale store is not cleared
module group_quant_gemv_row
	import gqg_pkg::*;
#(
	parameter int MAX_GROUPS = DEF_MAX_GROUPS,
	parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
	parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic push,
	output logic full,
	input item_t item,
	output logic empty,
	input logic pop,
	output result_t result
);

	logic [1:0] fmt_q;
	logic [GS_W-1:0] gsize_q;
	logic hd_valid;
	logic hd_pop;
	cmd_t hd;

	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_4BIT;
			gsize_q <= DEF_GROUP;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_FORMAT: fmt_q <= pwdata[1:0];
				REG_GROUP: gsize_q <= pwdata[GS_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[2])
			REG_FORMAT: prdata = {30'd0, fmt_q};
			REG_GROUP: prdata = {19'd0, gsize_q};
			default: prdata = '0;
		endcase
	end

	gqg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.weight_format(fmt_q),
		.push(push),
		.full(full),
		.item(item),
		.hd_valid(hd_valid),
		.hd(hd),
		.hd_pop(hd_pop)
	);

	gqg_back #(
		.MAX_GROUPS(MAX_GROUPS),
		.MAX_COLUMNS(MAX_COLUMNS),
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.grp_len(gsize_q),
		.hd_valid(hd_valid),
		.hd(hd),
		.hd_pop(hd_pop),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
